// File: hw/rtl/cfd_pkg.sv
// Shared constants and types for the CAN signal field decoder.
package cfd_pkg;

    localparam int DEF_MAX_SIGNAL_BYTES = 4;
    localparam int DEF_FRACTION_BITS    = 8;

    localparam int IN_W       = 64;
    localparam int OUT_W      = 58;
    localparam int TDATA_W    = ((OUT_W + 7) / 8) * 8;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int DEN_W      = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_BYTE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SIG_LEN    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LITTLE_END = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SIGNED     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_MULTIPLIER = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_DIVISOR    = 3'd7;

    localparam logic [2:0] CHAN_NONE     = 3'd0;
    localparam logic [2:0] CHAN_RESERVED = 3'd7;

    typedef struct packed {
        logic [2:0]  first_byte;
        logic [2:0]  sig_len;
        logic        little_endian;
        logic        signed_mode;
        logic [15:0] offset_value;
    } cfd_fmt_t;

    typedef struct packed {
        logic ok;
        logic neg;
    } cfd_side_t;

endpackage

// File: hw/rtl/cfd_extract.sv
// Byte extraction, sign extension (signed 1- and 2-byte signals only) and offset add, one register stage.
module cfd_extract #(
    parameter int MAX_SIGNAL_BYTES = cfd_pkg::DEF_MAX_SIGNAL_BYTES,
    localparam int RAW_W = 8 * MAX_SIGNAL_BYTES,
    localparam int V_W   = ((RAW_W > 16) ? RAW_W : 16) + 2
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic                     in_ok,
    input  logic [cfd_pkg::IN_W-1:0] frame,
    input  cfd_pkg::cfd_fmt_t        fmt,
    output logic                     out_valid,
    output logic                     out_ok,
    output logic [V_W-1:0]           v
);
    import cfd_pkg::*;

    logic [2:0]       n;
    logic [2:0]       src;
    logic [3:0]       idx;
    logic [RAW_W-1:0] raw;
    logic [V_W-1:0]   ext;
    logic [V_W-1:0]   sub;
    logic [V_W-1:0]   off;
    logic [V_W-1:0]   v_next;
    logic             valid_reg;
    logic             ok_reg;
    logic [V_W-1:0]   v_reg;

    always_comb
    begin
        n   = (fmt.sig_len > 3'(MAX_SIGNAL_BYTES)) ? 3'(MAX_SIGNAL_BYTES) : fmt.sig_len;
        raw = '0;
        src = '0;
        idx = '0;
        for (int k = 0; k < MAX_SIGNAL_BYTES; k++)
        begin
            if (3'(k) < n)
            begin
                src = fmt.little_endian ? 3'(k) : 3'(n - 3'(1) - 3'(k));
                idx = {1'b0, fmt.first_byte} + {1'b0, src};
                if (!idx[3])
                begin
                    raw[8*k +: 8] = frame[{idx[2:0], 3'b000} +: 8];
                end
            end
        end
        ext = V_W'(raw);
        sub = '0;
        if (fmt.signed_mode)
        begin
            if (n == 3'd1 && ext[7])
            begin
                sub = V_W'(256);
            end
            else if (n == 3'd2 && ext[15])
            begin
                sub = V_W'(65536);
            end
        end
        off    = {{(V_W-16){fmt.offset_value[15]}}, fmt.offset_value};
        v_next = ext - sub + off;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok_reg <= in_ok;
            v_reg  <= v_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ok    = ok_reg;
    assign v         = v_reg;

endmodule

// File: hw/rtl/cfd_scale.sv
// Magnitude split and multiply by the scale multiplier, two register stages.
module cfd_scale #(
    parameter int V_W = 34,
    localparam int P_W = V_W + cfd_pkg::DEN_W
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic                      in_ok,
    input  logic [V_W-1:0]            v,
    input  logic [cfd_pkg::DEN_W-1:0] mult,
    output logic                      out_valid,
    output cfd_pkg::cfd_side_t        out_side,
    output logic [P_W-1:0]            p
);
    import cfd_pkg::*;

    logic            a_valid_reg;
    cfd_side_t       a_side_reg;
    logic [V_W-1:0]  a_mag_reg;
    logic            b_valid_reg;
    cfd_side_t       b_side_reg;
    logic [P_W-1:0]  b_p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_side_reg.ok  <= in_ok;
            a_side_reg.neg <= v[V_W-1];
            a_mag_reg      <= v[V_W-1] ? (V_W'(0) - v) : v;
            b_side_reg     <= a_side_reg;
            b_p_reg        <= P_W'(a_mag_reg) * P_W'(mult);
        end
    end

    assign out_valid = b_valid_reg;
    assign out_side  = b_side_reg;
    assign p         = b_p_reg;

endmodule

// File: hw/rtl/cfd_div.sv
// Restoring divider, one quotient bit per pipeline stage.
module cfd_div #(
    parameter int N_W = 58
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  cfd_pkg::cfd_side_t        in_side,
    input  logic [N_W-1:0]            num,
    input  logic [cfd_pkg::DEN_W-1:0] den,
    output logic                      out_valid,
    output cfd_pkg::cfd_side_t        out_side,
    output logic [N_W-1:0]            quo
);
    import cfd_pkg::*;

    // work holds the dividend bits still to go above the quotient bits so far
    logic [N_W-1:0]   work_reg  [N_W];
    logic [DEN_W-1:0] rem_reg   [N_W];
    cfd_side_t        side_reg  [N_W];
    logic             valid_reg [N_W];

    for (genvar j = 0; j < N_W; j++)
    begin : g_stage
        logic [N_W-1:0]   w_in;
        logic [DEN_W-1:0] r_in;
        cfd_side_t        s_in;
        logic             v_in;
        logic [DEN_W:0]   trial;
        logic             ge;

        if (j == 0)
        begin : g_first
            assign w_in = num;
            assign r_in = '0;
            assign s_in = in_side;
            assign v_in = in_valid;
        end
        else
        begin : g_rest
            assign w_in = work_reg[j-1];
            assign r_in = rem_reg[j-1];
            assign s_in = side_reg[j-1];
            assign v_in = valid_reg[j-1];
        end

        assign trial = {r_in, w_in[N_W-1]};
        assign ge    = trial >= {1'b0, den};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                work_reg[j] <= {w_in[N_W-2:0], ge};
                rem_reg[j]  <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
                side_reg[j] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[N_W-1];
    assign out_side  = side_reg[N_W-1];
    assign quo       = work_reg[N_W-1];

endmodule

// File: hw/rtl/can_signal_field_decoder.sv
// Top level of the CAN signal field decoder: config registers, pipeline, output stage.
// Throughput: one request per cycle unless the output stalls; the divider retires one quotient bit per stage.
// The whole pipeline holds while the output register is full and m_tready is low.
// Reset (rst_n, async, active low) empties the pipeline and restores register defaults.
module can_signal_field_decoder #(
    parameter int MAX_SIGNAL_BYTES = cfd_pkg::DEF_MAX_SIGNAL_BYTES,
    parameter int FRACTION_BITS    = cfd_pkg::DEF_FRACTION_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cfd_pkg::IN_W-1:0]       s_tdata,   // frame_bytes
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cfd_pkg::TDATA_W-1:0]    m_tdata,   // physical_value, zero pad
    output logic                           m_tuser,   // value_valid
    input  logic                           cfg_we,
    input  logic [cfd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cfd_pkg::CFG_W-1:0]      cfg_data
);
    import cfd_pkg::*;

    localparam int RAW_W = 8 * MAX_SIGNAL_BYTES;
    localparam int V_W   = ((RAW_W > 16) ? RAW_W : 16) + 2;
    localparam int P_W   = V_W + DEN_W;
    localparam int N_W   = P_W + FRACTION_BITS;
    localparam int CMP_W = (N_W > OUT_W) ? N_W : OUT_W;

    logic [2:0]       channel_reg;
    cfd_fmt_t         fmt_reg;
    logic [DEN_W-1:0] mult_reg;
    logic [DEN_W-1:0] div_reg;

    logic             adv;
    logic             chan_ok;
    logic [DEN_W-1:0] mult_eff;
    logic [DEN_W-1:0] den_eff;

    logic             ex_valid;
    logic             ex_ok;
    logic [V_W-1:0]   ex_v;
    logic             sc_valid;
    cfd_side_t        sc_side;
    logic [P_W-1:0]   sc_p;
    logic             dv_valid;
    cfd_side_t        dv_side;
    logic [N_W-1:0]   dv_quo;

    logic [CMP_W-1:0] qx;
    logic [CMP_W-1:0] cap;
    logic [CMP_W-1:0] mag;
    logic [OUT_W-1:0] phys_next;

    logic             out_valid_reg;
    logic [OUT_W-1:0] phys_reg;
    logic             vv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_reg           <= '0;
            fmt_reg.first_byte    <= '0;
            fmt_reg.sig_len       <= 3'd1;
            fmt_reg.little_endian <= 1'b0;
            fmt_reg.signed_mode   <= 1'b0;
            fmt_reg.offset_value  <= '0;
            mult_reg              <= DEN_W'(1);
            div_reg               <= DEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_CHANNEL:    channel_reg           <= cfg_data[2:0];
                REG_FIRST_BYTE: fmt_reg.first_byte    <= cfg_data[2:0];
                REG_SIG_LEN:    fmt_reg.sig_len       <= cfg_data[2:0];
                REG_LITTLE_END: fmt_reg.little_endian <= cfg_data[0];
                REG_SIGNED:     fmt_reg.signed_mode   <= cfg_data[0];
                REG_OFFSET:     fmt_reg.offset_value  <= cfg_data[15:0];
                REG_MULTIPLIER: mult_reg              <= cfg_data[DEN_W-1:0];
                REG_DIVISOR:    div_reg               <= cfg_data[DEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign chan_ok  = (channel_reg != CHAN_NONE) && (channel_reg != CHAN_RESERVED);
    // zero divisor: pass the offset sum through unscaled
    assign mult_eff = (div_reg == '0) ? DEN_W'(1) : mult_reg;
    assign den_eff  = (div_reg == '0) ? DEN_W'(1) : div_reg;

    cfd_extract #(
        .MAX_SIGNAL_BYTES(MAX_SIGNAL_BYTES)
    ) u_extract (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_ok     (chan_ok),
        .frame     (s_tdata),
        .fmt       (fmt_reg),
        .out_valid (ex_valid),
        .out_ok    (ex_ok),
        .v         (ex_v)
    );

    cfd_scale #(
        .V_W(V_W)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (ex_valid),
        .in_ok     (ex_ok),
        .v         (ex_v),
        .mult      (mult_eff),
        .out_valid (sc_valid),
        .out_side  (sc_side),
        .p         (sc_p)
    );

    cfd_div #(
        .N_W(N_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sc_valid),
        .in_side   (sc_side),
        .num       (N_W'(sc_p) << FRACTION_BITS),
        .den       (den_eff),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .quo       (dv_quo)
    );

    always_comb
    begin
        qx  = CMP_W'(dv_quo);
        cap = dv_side.neg ? (CMP_W'(1) << (OUT_W - 1))
                          : ((CMP_W'(1) << (OUT_W - 1)) - CMP_W'(1));
        mag = (qx > cap) ? cap : qx;
        if (!dv_side.ok)
        begin
            phys_next = '0;
        end
        else if (dv_side.neg)
        begin
            phys_next = OUT_W'(CMP_W'(0) - mag);
        end
        else
        begin
            phys_next = OUT_W'(mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            phys_reg <= phys_next;
            vv_reg   <= dv_side.ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(phys_reg);
    assign m_tuser  = vv_reg;

endmodule
